@@ rtl/scpa_pkg.sv @@
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and codes for the size class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int OWNER_W = 22;
    localparam int SIZE_W  = 37;
    localparam int ADDR_W  = 48;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_ASSIGN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REF    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_SMALL  = 2'd1;
    localparam logic [1:0] REG_MIDDLE = 2'd2;
    localparam logic [1:0] REG_LARGE  = 2'd3;

    localparam logic [ADDR_W-1:0] BASE_RESET   = 48'h0400_0000_0000;
    localparam logic [SIZE_W-1:0] SMALL_RESET  = 37'd134217728;
    localparam logic [SIZE_W-1:0] MIDDLE_RESET = 37'd1073741824;
    localparam logic [SIZE_W-1:0] LARGE_RESET  = 37'd8589934592;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic hit;
        logic take_addr;
    } hit_t;

endpackage

@@ rtl/size_class_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// Pool table in three size classes with per-pool owner and reference count.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  s_axis    in   tdata: action, owner_id, request_bytes
//  m_axis    out  tdata: pool_address, status
//  apb       in   base_address, small/middle/large_pool_bytes at 8*i
//
//  for each request the pool table, a ring of cells, rotates once, one entry
//  through the head update per cycle; the running pool address is one add per
//  cycle
//  reset clears every cell at once, so no clearing pass is needed
//  a result waits in the output register while the next request is taken
module size_class_pool_allocator #(
    parameter int SMALL_POOLS  = 1000,
    parameter int MIDDLE_POOLS = 100,
    parameter int LARGE_POOLS  = 10,
    parameter int REF_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // action[1:0], owner_id[23:2], request_bytes[60:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // pool_address[47:0], status[48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int TOTAL = SMALL_POOLS + MIDDLE_POOLS + LARGE_POOLS;
    localparam int IDX_W = $clog2(TOTAL);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TOTAL - 1);
    localparam logic [IDX_W-1:0] IDX_MIDDLE = IDX_W'(SMALL_POOLS);
    localparam logic [IDX_W-1:0] IDX_LARGE  = IDX_W'(SMALL_POOLS + MIDDLE_POOLS);

    localparam int OW = scpa_pkg::OWNER_W;
    localparam int SW = scpa_pkg::SIZE_W;
    localparam int AW = scpa_pkg::ADDR_W;

    logic [AW-1:0] base_reg;
    logic [SW-1:0] small_reg;
    logic [SW-1:0] middle_reg;
    logic [SW-1:0] large_reg;

    scpa_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [scpa_pkg::ACT_W-1:0] act_reg;
    logic [OW-1:0]             oid_reg;
    logic [SW-1:0]             want_reg;
    logic                      found_reg, found_next;
    logic [AW-1:0]             run_reg, run_next;
    logic [AW-1:0]             res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    logic [AW-1:0]             out_addr_reg;
    logic                      out_status_reg;

    logic          wr_en;
    logic          accept;
    logic          shift;
    logic          load_out;
    logic [SW-1:0] size;

    logic [OW-1:0]       owner_w [TOTAL];
    logic [REF_BITS-1:0] refs_w  [TOTAL];
    logic [OW-1:0]       owner_h;
    logic [REF_BITS-1:0] refs_h;
    scpa_pkg::hit_t      hit;

    // configuration
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= scpa_pkg::BASE_RESET;
            small_reg  <= scpa_pkg::SMALL_RESET;
            middle_reg <= scpa_pkg::MIDDLE_RESET;
            large_reg  <= scpa_pkg::LARGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:3])
                scpa_pkg::REG_BASE:   base_reg   <= pwdata[AW-1:0];
                scpa_pkg::REG_SMALL:  small_reg  <= pwdata[SW-1:0];
                scpa_pkg::REG_MIDDLE: middle_reg <= pwdata[SW-1:0];
                scpa_pkg::REG_LARGE:  large_reg  <= pwdata[SW-1:0];
                default:              base_reg   <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            scpa_pkg::REG_BASE:   prdata = {16'd0, base_reg};
            scpa_pkg::REG_SMALL:  prdata = {27'd0, small_reg};
            scpa_pkg::REG_MIDDLE: prdata = {27'd0, middle_reg};
            scpa_pkg::REG_LARGE:  prdata = {27'd0, large_reg};
            default:              prdata = '0;
        endcase
    end

    // pool table ring
    genvar k;
    generate
        for (k = 0; k < TOTAL; k++)
        begin : g_cell
            if (k == TOTAL - 1)
            begin : g_tail
                scpa_cell #(.REF_BITS(REF_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .owner_in  (owner_h),
                    .refs_in   (refs_h),
                    .owner_out (owner_w[k]),
                    .refs_out  (refs_w[k])
                );
            end
            else
            begin : g_mid
                scpa_cell #(.REF_BITS(REF_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .owner_in  (owner_w[k+1]),
                    .refs_in   (refs_w[k+1]),
                    .owner_out (owner_w[k]),
                    .refs_out  (refs_w[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        if (idx_reg < IDX_MIDDLE)
            size = small_reg;
        else if (idx_reg < IDX_LARGE)
            size = middle_reg;
        else
            size = large_reg;
    end

    scpa_head #(.REF_BITS(REF_BITS)) u_head (
        .action   (act_reg),
        .owner_id (oid_reg),
        .want     (want_reg),
        .size     (size),
        .found    (found_reg),
        .owner_e  (owner_w[0]),
        .refs_e   (refs_w[0]),
        .owner_n  (owner_h),
        .refs_n   (refs_h),
        .hit      (hit)
    );

    // control
    assign s_axis_tready = (state_reg == scpa_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign shift         = (state_reg == scpa_pkg::ST_SCAN);
    assign load_out      = (state_reg == scpa_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        run_next       = run_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            scpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    run_next   = base_reg;
                    res_next   = '0;
                    state_next = scpa_pkg::ST_SCAN;
                end
            end
            scpa_pkg::ST_SCAN:
            begin
                if (hit.hit)
                    found_next = 1'b1;
                if (hit.take_addr)
                    res_next = run_reg;
                run_next = run_reg + {{(AW-SW){1'b0}}, size};
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = scpa_pkg::ST_DONE;
                end
                else
                    idx_next = idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
            end
            scpa_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = scpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scpa_pkg::ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        res_reg <= res_next;
        if (accept)
        begin
            act_reg  <= s_axis_tdata[1:0];
            oid_reg  <= s_axis_tdata[23:2];
            want_reg <= s_axis_tdata[60:24];
        end
        if (load_out)
        begin
            out_addr_reg   <= res_reg;
            out_status_reg <= !found_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_addr_reg};

    // checks
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != scpa_pkg::ST_SCAN) |-> (idx_reg == '0))
        else $error("scan index not at zero outside scan");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scpa_pkg::ST_SCAN && idx_reg == IDX_LAST) |=>
        (state_reg == scpa_pkg::ST_DONE))
        else $error("scan did not end after last entry");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_axis_tvalid)
        else $error("result not presented after load");

endmodule

@@ rtl/scpa_cell.sv @@
// ----------------------------------------------------------------------------
// scpa_cell
// One pool entry of the rotating table: owner id and reference count.
// ----------------------------------------------------------------------------
module scpa_cell #(
    parameter int REF_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic [scpa_pkg::OWNER_W-1:0] owner_in,
    input  logic [REF_BITS-1:0]          refs_in,
    output logic [scpa_pkg::OWNER_W-1:0] owner_out,
    output logic [REF_BITS-1:0]          refs_out
);

    logic [scpa_pkg::OWNER_W-1:0] owner_reg;
    logic [REF_BITS-1:0]          refs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            refs_reg  <= '0;
        end
        else if (shift)
        begin
            owner_reg <= owner_in;
            refs_reg  <= refs_in;
        end
    end

    assign owner_out = owner_reg;
    assign refs_out  = refs_reg;

endmodule

@@ rtl/scpa_head.sv @@
// ----------------------------------------------------------------------------
// scpa_head
// Update of the entry at the head of the table for the request in flight.
// ----------------------------------------------------------------------------
module scpa_head #(
    parameter int REF_BITS = 16
) (
    input  logic [scpa_pkg::ACT_W-1:0]   action,
    input  logic [scpa_pkg::OWNER_W-1:0] owner_id,
    input  logic [scpa_pkg::SIZE_W-1:0]  want,
    input  logic [scpa_pkg::SIZE_W-1:0]  size,
    input  logic                         found,
    input  logic [scpa_pkg::OWNER_W-1:0] owner_e,
    input  logic [REF_BITS-1:0]          refs_e,
    output logic [scpa_pkg::OWNER_W-1:0] owner_n,
    output logic [REF_BITS-1:0]          refs_n,
    output scpa_pkg::hit_t               hit
);

    logic                valid_id;
    logic                match;
    logic [REF_BITS-1:0] dec;

    assign valid_id = (owner_id != '0);
    assign match    = valid_id && (owner_e == owner_id);
    assign dec      = (refs_e != '0) ? refs_e - {{(REF_BITS-1){1'b0}}, 1'b1} : refs_e;

    always_comb
    begin
        owner_n       = owner_e;
        refs_n        = refs_e;
        hit.hit       = 1'b0;
        hit.take_addr = 1'b0;
        case (action)
            scpa_pkg::ACT_ASSIGN:
            begin
                if (valid_id && !found && owner_e == '0 && want <= size)
                begin
                    owner_n       = owner_id;
                    refs_n        = {{(REF_BITS-1){1'b0}}, 1'b1};
                    hit.hit       = 1'b1;
                    hit.take_addr = 1'b1;
                end
            end
            scpa_pkg::ACT_REF:
            begin
                if (match)
                begin
                    if (refs_e != '1)
                        refs_n = refs_e + {{(REF_BITS-1){1'b0}}, 1'b1};
                    hit.hit = 1'b1;
                end
            end
            scpa_pkg::ACT_FREE:
            begin
                if (match && !found)
                begin
                    refs_n = dec;
                    if (dec == '0)
                        owner_n = '0;
                    hit.hit = 1'b1;
                end
            end
            default:
            begin
                hit.hit = 1'b0;
            end
        endcase
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Allocator check: assign, reference and free requests go in as stream
// beats and every result is held against a pool table kept in the bench,
// over several pool size and base address settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NS    = 1000;
    localparam int NM    = 100;
    localparam int NL    = 10;
    localparam int NPOOL = NS + NM + NL;
    localparam int REFW  = 16;
    localparam logic [REFW-1:0] REF_TOP = '1;

    typedef struct packed {
        logic [scpa_pkg::ACT_W-1:0]   action;
        logic [scpa_pkg::OWNER_W-1:0] owner_id;
        logic [scpa_pkg::SIZE_W-1:0]  request_bytes;
    } request_t;

    typedef struct packed {
        logic [scpa_pkg::ADDR_W-1:0] pool_address;
        logic                        status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    size_class_pool_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [scpa_pkg::ADDR_W-1:0]  base_addr;
    logic [scpa_pkg::SIZE_W-1:0]  class_bytes [3];
    logic [scpa_pkg::OWNER_W-1:0] owner_tab [NPOOL];
    logic [REFW-1:0]              refs_tab [NPOOL];

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    int       errors;
    int       grants_seen;
    int       reqs_sent;
    bit       calm;
    bit       hold_off;
    int       hold_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [scpa_pkg::ADDR_W-1:0] pool_addr_of(int i);
        logic [63:0] a;
        int ns, nm, nl;
        ns = (i < NS) ? i : NS;
        nm = (i < NS) ? 0 : ((i < NS + NM) ? i - NS : NM);
        nl = (i < NS + NM) ? 0 : i - NS - NM;
        a = 64'(base_addr) + 64'(ns) * class_bytes[0] + 64'(nm) * class_bytes[1]
            + 64'(nl) * class_bytes[2];
        return a[scpa_pkg::ADDR_W-1:0];
    endfunction

    function automatic int class_of(int i);
        return (i < NS) ? 0 : ((i < NS + NM) ? 1 : 2);
    endfunction

    function automatic grant_t allocate(request_t r);
        grant_t g;
        g.pool_address = '0;
        g.status = 1'b1;
        if (r.owner_id != 0)
        begin
            if (r.action == scpa_pkg::ACT_ASSIGN)
            begin
                for (int i = 0; i < NPOOL; i++)
                begin
                    if (owner_tab[i] == 0 && r.request_bytes <= class_bytes[class_of(i)])
                    begin
                        owner_tab[i] = r.owner_id;
                        refs_tab[i] = REFW'(1);
                        g.pool_address = pool_addr_of(i);
                        g.status = 1'b0;
                        break;
                    end
                end
            end
            else if (r.action == scpa_pkg::ACT_REF)
            begin
                for (int i = 0; i < NPOOL; i++)
                begin
                    if (owner_tab[i] == r.owner_id)
                    begin
                        if (refs_tab[i] != REF_TOP)
                            refs_tab[i]++;
                        g.status = 1'b0;
                    end
                end
            end
            else if (r.action == scpa_pkg::ACT_FREE)
            begin
                for (int i = 0; i < NPOOL; i++)
                begin
                    if (owner_tab[i] == r.owner_id)
                    begin
                        if (refs_tab[i] != 0)
                            refs_tab[i]--;
                        if (refs_tab[i] == 0)
                            owner_tab[i] = '0;
                        g.status = 1'b0;
                        break;
                    end
                end
            end
        end
        return g;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                reqs_sent++;
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 17))
            begin
                request_t r;
                r = pending_reqs.pop_front();
                expected_grants.push_back(allocate(r));
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b0, r.request_bytes, r.owner_id, r.action};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            grants_seen++;
            if (expected_grants.size() == 0)
            begin
                report("unexpected beat", 64'(m_axis_tdata), 64'd0);
            end
            else
            begin
                grant_t w;
                w = expected_grants.pop_front();
                if (m_axis_tdata[47:0] !== w.pool_address)
                    report("pool_address", 64'(m_axis_tdata[47:0]), 64'(w.pool_address));
                if (m_axis_tdata[48] !== w.status)
                    report("status", 64'(m_axis_tdata[48]), 64'(w.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_off <= 1'b0;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == scpa_pkg::REG_BASE)
            base_addr = val[scpa_pkg::ADDR_W-1:0];
        else
            class_bytes[idx - 2'd1] = val[scpa_pkg::SIZE_W-1:0];
    endtask

    task automatic settle();
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (expected_grants.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (NPOOL + 20) @(posedge clk);
    endtask

    function automatic request_t make_req(logic [scpa_pkg::ACT_W-1:0] a,
                                          logic [scpa_pkg::OWNER_W-1:0] o,
                                          logic [scpa_pkg::SIZE_W-1:0] b);
        request_t r;
        r.action = a;
        r.owner_id = o;
        r.request_bytes = b;
        return r;
    endfunction

    function automatic logic [scpa_pkg::SIZE_W-1:0] rand_bytes();
        logic [scpa_pkg::SIZE_W-1:0] b;
        case ($urandom_range(5))
            0: b = '0;
            1: b = class_bytes[$urandom_range(2)];
            2: b = class_bytes[$urandom_range(2)] + 37'd1;
            3: b = 37'({$urandom(), $urandom()});
            default: b = 37'($urandom_range(1 << 20)) % (class_bytes[0] + 37'd1);
        endcase
        return b;
    endfunction

    task automatic random_phase(int count);
        logic [scpa_pkg::OWNER_W-1:0] ids [8];
        for (int k = 0; k < 8; k++)
            ids[k] = 22'($urandom_range(1, 22'h3FFFFF));
        for (int k = 0; k < count; k++)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 90)
                pending_reqs.push_back(make_req(2'($urandom_range(2)),
                                       ids[$urandom_range(7)], rand_bytes()));
            else
                pending_reqs.push_back(make_req(2'($urandom_range(3)),
                                       (pick < 94) ? 22'd0 : 22'($urandom()),
                                       37'({$urandom(), $urandom()})));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        grants_seen = 0;
        reqs_sent = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        base_addr = scpa_pkg::BASE_RESET;
        class_bytes[0] = scpa_pkg::SMALL_RESET;
        class_bytes[1] = scpa_pkg::MIDDLE_RESET;
        class_bytes[2] = scpa_pkg::LARGE_RESET;
        for (int i = 0; i < NPOOL; i++)
        begin
            owner_tab[i] = '0;
            refs_tab[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset sizes
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'h3FFFFF, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd1, scpa_pkg::LARGE_RESET));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd1,
                                        scpa_pkg::LARGE_RESET + 37'd1));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd2, 37'h1F_FFFF_FFFF));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd0, 37'd5));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_REF, 22'd0, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd0, 37'd0));
        pending_reqs.push_back(make_req(2'd3, 22'd1, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_REF, 22'd1, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd1, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd1, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd1, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_REF, 22'd77, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd77, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd3, scpa_pkg::MIDDLE_RESET));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd3,
                                        scpa_pkg::SMALL_RESET + 37'd1));
        settle();

        // zero-size pools, wrapping addresses
        reg_write(scpa_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF);
        reg_write(scpa_pkg::REG_SMALL, 64'd0);
        reg_write(scpa_pkg::REG_MIDDLE, 64'h10_0000_0000);
        reg_write(scpa_pkg::REG_LARGE, 64'd1);
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd9, 37'd0));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd9, 37'd1));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd9, 37'h10_0000_0000));
        pending_reqs.push_back(make_req(scpa_pkg::ACT_FREE, 22'd9, 37'd0));
        random_phase(120);

        // zero base, one-byte small pools
        settle();
        reg_write(scpa_pkg::REG_BASE, 64'd0);
        reg_write(scpa_pkg::REG_SMALL, 64'd1);
        reg_write(scpa_pkg::REG_MIDDLE, 64'h10_0000_0000);
        reg_write(scpa_pkg::REG_LARGE, 64'h10_0000_0000);
        pending_reqs.push_back(make_req(scpa_pkg::ACT_ASSIGN, 22'd5, 37'd1));
        random_phase(140);

        // receiver held off while requests keep coming
        settle();
        reg_write(scpa_pkg::REG_BASE, 64'h1234_5678_9ABC);
        reg_write(scpa_pkg::REG_SMALL, 64'd4096);
        reg_write(scpa_pkg::REG_MIDDLE, 64'd65536);
        reg_write(scpa_pkg::REG_LARGE, 64'd1048576);
        hold_off <= 1'b1;
        hold_cycles <= 4000;
        random_phase(140);

        settle();
        calm = 1'b1;
        reg_write(scpa_pkg::REG_SMALL, 64'd100);
        random_phase(120);

        settle();
        repeat (2 * NPOOL) @(posedge clk);
        $display("tb_top: %0d requests, %0d results, 5 pool settings incl. zero size and wrap",
                 reqs_sent, grants_seen);
        if (errors == 0 && expected_grants.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/scpa_pkg.sv
rtl/scpa_cell.sv
rtl/scpa_head.sv
rtl/size_class_pool_allocator.sv
tb/tb_top.sv
